### src/ordered_keyword_matcher_assert.svh
// Assertion macros for the ordered keyword matcher checks.
// Each takes a label, an antecedent, a consequent and a message.
// The enclosing module provides clk and rst.
`ifndef ORDERED_KEYWORD_MATCHER_ASSERT_SVH
`define ORDERED_KEYWORD_MATCHER_ASSERT_SVH

// Same-cycle implication.
`define OKM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/okm_pkg.sv
`timescale 1ns / 1ps

package okm_pkg;

  // Build defaults
  localparam int MAX_WORDS_DEF    = 4;
  localparam int MAX_WORD_LEN_DEF = 8;

  // Keyword registers present in the register map
  localparam int KW_REGS = 4;

  // Field widths
  localparam int CH_W     = 8;
  localparam int WORDS_W  = 3;
  localparam int KW_W     = 64;
  localparam int LENS_W   = 16;
  localparam int LEN_F_W  = 4;
  localparam int COUNT_W  = 3;

  // Register port
  localparam int APB_AW = 6;
  localparam int APB_DW = 64;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_SEL_W   = 3;

  // Register indexes
  localparam logic [REG_SEL_W-1:0] REG_KW0   = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_KW1   = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_KW2   = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_KW3   = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_LENS  = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_COUNT = 3'd5;

  // Lower ASCII capitals; leave every other byte alone.
  function automatic logic [CH_W-1:0] fold(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

### src/okm_intf.sv
`timescale 1ns / 1ps

interface okm_char_if;
  logic                   valid;
  logic                   ready;
  logic [okm_pkg::CH_W-1:0] ch;
  logic                   has_char;
  logic                   last;

  modport source (output valid, output ch, output has_char, output last, input ready);
  modport sink   (input valid, input ch, input has_char, input last, output ready);
endinterface

interface okm_res_if;
  logic                        valid;
  logic                        ready;
  logic                        matched;
  logic [okm_pkg::WORDS_W-1:0] words_found;

  modport source (output valid, output matched, output words_found, input ready);
  modport sink   (input valid, input matched, input words_found, output ready);
endinterface

### src/ordered_keyword_matcher.sv
`timescale 1ns / 1ps

// Ordered keyword matcher: takes one character word per cycle on chars while chars.ready is high
// and, on the word that carries last, delivers one result word on result telling whether every
// keyword in use was found in order (case-insensitive for A-Z, no overlap, each search starting
// after the end of the previous keyword's first match) and how many were found. Keywords, their
// lengths and the count are written over the APB port at byte address 8*i (keyword_0..3,
// keyword_lengths, keyword_count); write them only while no string is in flight. Throughput is
// one character word per cycle while chars.ready is high: the whole search step (window shift,
// compare against the keyword being sought, advance past empty keywords) is one shallow layer of
// logic between the search state registers. A result is registered into the result register, or
// into the skid slot while that register is stalled; this two-deep result buffer lets characters
// keep flowing while a result waits, and chars.ready drops only when two results are waiting.
module ordered_keyword_matcher #(
  parameter int MAX_WORDS    = okm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_LEN = okm_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  okm_char_if.sink                    chars,
  okm_res_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [okm_pkg::APB_AW-1:0]  paddr,
  input  logic [okm_pkg::APB_DW-1:0]  pwdata,
  output logic [okm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  // Keywords actually searchable: bounded by MAX_WORDS and by the register map
  localparam int NW = (MAX_WORDS < okm_pkg::KW_REGS) ? MAX_WORDS : okm_pkg::KW_REGS;
  localparam int IW = $clog2(NW + 1);
  localparam int L  = MAX_WORD_LEN;
  localparam int LW = $clog2(L + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [okm_pkg::KW_W-1:0]    keyword [okm_pkg::KW_REGS];
  logic [okm_pkg::LENS_W-1:0]  kw_lens;
  logic [okm_pkg::COUNT_W-1:0] kw_count;

  logic                          wr_en;
  logic [okm_pkg::REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[okm_pkg::REG_SEL_LSB +: okm_pkg::REG_SEL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < okm_pkg::KW_REGS; k++) begin
        keyword[k] <= '0;
      end
      kw_lens  <= '0;
      kw_count <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        okm_pkg::REG_KW0:   keyword[0] <= pwdata;
        okm_pkg::REG_KW1:   keyword[1] <= pwdata;
        okm_pkg::REG_KW2:   keyword[2] <= pwdata;
        okm_pkg::REG_KW3:   keyword[3] <= pwdata;
        okm_pkg::REG_LENS:  kw_lens    <= pwdata[okm_pkg::LENS_W-1:0];
        okm_pkg::REG_COUNT: kw_count   <= pwdata[okm_pkg::COUNT_W-1:0];
        default: ;  // unmapped: drop
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      okm_pkg::REG_KW0:   prdata = keyword[0];
      okm_pkg::REG_KW1:   prdata = keyword[1];
      okm_pkg::REG_KW2:   prdata = keyword[2];
      okm_pkg::REG_KW3:   prdata = keyword[3];
      okm_pkg::REG_LENS:  prdata = okm_pkg::APB_DW'(kw_lens);
      okm_pkg::REG_COUNT: prdata = okm_pkg::APB_DW'(kw_count);
      default:            prdata = '0;
    endcase
  end

  // Keywords in use, clamped to what the block can hold
  logic [IW-1:0] n_used;
  assign n_used = (kw_count > okm_pkg::COUNT_W'(NW)) ? IW'(NW) : IW'(kw_count);

  // Clamped lengths, one per keyword
  logic [LW-1:0] len_c [NW];
  always_comb begin
    for (int j = 0; j < NW; j++) begin
      if (kw_lens[okm_pkg::LEN_F_W*j +: okm_pkg::LEN_F_W] > okm_pkg::LEN_F_W'(L)) begin
        len_c[j] = LW'(L);
      end else begin
        len_c[j] = LW'(kw_lens[okm_pkg::LEN_F_W*j +: okm_pkg::LEN_F_W]);
      end
    end
  end

  // Step past empty keywords, starting at idx, never beyond the count in use.
  function automatic logic [IW-1:0] skip_empty(input logic [IW-1:0] idx,
                                               input logic [IW-1:0] n,
                                               input logic [LW-1:0] lens [NW]);
    logic [IW-1:0] r;
    logic          stop;
    r    = idx;
    stop = 1'b0;
    for (int j = 0; j < NW; j++) begin
      if (!stop && IW'(j) >= idx) begin
        if (IW'(j) < n && lens[j] == '0) begin
          r = IW'(j + 1);
        end else begin
          stop = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Search state: lowered window (newest at 0), characters since the last
  // restart, and the keyword being sought
  // ---------------------------------------------------------------------------
  logic [okm_pkg::CH_W-1:0] window      [L];
  logic [okm_pkg::CH_W-1:0] window_next [L];
  logic [LW-1:0]            since;
  logic [LW-1:0]            since_next;
  logic [IW-1:0]            word_idx;
  logic [IW-1:0]            word_idx_next;

  logic [IW-1:0]         idx_s;      // after leading empty keywords
  logic [LW-1:0]         since_inc;
  logic [LW-1:0]         sel_len;
  logic [okm_pkg::KW_W-1:0] sel_kw;
  logic                  bytes_eq;
  logic                  hit;
  logic [IW-1:0]         found;
  logic                  take;
  logic                  res_take;
  logic                  res_matched;
  logic [okm_pkg::WORDS_W-1:0] res_words;

  always_comb begin
    idx_s = skip_empty(word_idx, n_used, len_c);

    // Shift in the folded character
    for (int p = 0; p < L; p++) begin
      window_next[p] = window[p];
    end
    if (chars.has_char) begin
      for (int p = L - 1; p > 0; p--) begin
        window_next[p] = window[p-1];
      end
      window_next[0] = okm_pkg::fold(chars.ch);
    end

    since_inc = (since < LW'(L)) ? since + 1'b1 : since;

    // Pick the keyword being sought
    sel_len = '0;
    sel_kw  = '0;
    for (int j = 0; j < NW; j++) begin
      if (idx_s == IW'(j)) begin
        sel_len = len_c[j];
        sel_kw  = keyword[j];
      end
    end

    // Keyword byte i lines up with window slot len-1-i
    bytes_eq = 1'b1;
    for (int p = 0; p < L; p++) begin
      for (int i = 0; i < L; i++) begin
        if (i + p + 1 == int'(sel_len)) begin
          if (window_next[p] != okm_pkg::fold(sel_kw[okm_pkg::CH_W*i +: okm_pkg::CH_W])) begin
            bytes_eq = 1'b0;
          end
        end
      end
    end

    hit = chars.has_char && (idx_s < n_used) && (sel_len != '0) &&
          (since_inc >= sel_len) && bytes_eq;

    if (hit) begin
      word_idx_next = skip_empty(idx_s + 1'b1, n_used, len_c);
      since_next    = '0;
    end else begin
      word_idx_next = idx_s;
      since_next    = chars.has_char ? since_inc : since;
    end

    found       = (word_idx_next > n_used) ? n_used : word_idx_next;
    res_matched = (found >= n_used);
    res_words   = okm_pkg::WORDS_W'(found);
  end

  assign take     = chars.valid && chars.ready;
  assign res_take = take && chars.last;

  // Clear the search at every string end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < L; p++) begin
        window[p] <= '0;
      end
      since    <= '0;
      word_idx <= '0;
    end else if (take) begin
      if (chars.last) begin
        for (int p = 0; p < L; p++) begin
          window[p] <= '0;
        end
        since    <= '0;
        word_idx <= '0;
      end else begin
        window   <= window_next;
        since    <= since_next;
        word_idx <= word_idx_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register with a skid slot behind it
  // ---------------------------------------------------------------------------
  logic                        out_valid;
  logic                        out_matched;
  logic [okm_pkg::WORDS_W-1:0] out_words;
  logic                        skid_valid;
  logic                        skid_matched;
  logic [okm_pkg::WORDS_W-1:0] skid_words;
  logic                        out_stall;

  assign out_stall   = out_valid && !result.ready;
  assign chars.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_stall) begin
      if (res_take) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_stall) begin
      if (res_take) begin
        skid_matched <= res_matched;
        skid_words   <= res_words;
      end
    end else if (skid_valid) begin
      out_matched <= skid_matched;
      out_words   <= skid_words;
    end else if (res_take) begin
      out_matched <= res_matched;
      out_words   <= res_words;
    end
  end

  assign result.valid       = out_valid;
  assign result.matched     = out_matched;
  assign result.words_found = out_words;

endmodule

### src/okm_checker.sv
`timescale 1ns / 1ps
`include "ordered_keyword_matcher_assert.svh"

module okm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        res_matched,
  input logic [okm_pkg::WORDS_W-1:0] res_words
);

  // A stalled result stays offered
  `OKM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

  // ...with the same contents
  `OKM_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_matched) && $stable(res_words), "result changed while stalled")

  // A new result follows only a taken end-of-string word
  `OKM_ASSERT_NOW(a_res_cause, $rose(res_valid), $past(in_valid && in_ready && in_last), "result without end of string")

  // Input back-pressure only when a result is already waiting
  `OKM_ASSERT_NOW(a_bp_cause, !in_ready, res_valid, "input held off with no result pending")

endmodule

bind ordered_keyword_matcher okm_checker u_okm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .in_last     (chars.last),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_matched (result.matched),
  .res_words   (result.words_found)
);

### verif/tb_ordered_keyword_matcher.sv
`timescale 1ns / 1ps

// What the block owes us for one string: the verdict word on result.
typedef struct packed {
  logic                        matched;
  logic [okm_pkg::WORDS_W-1:0] words_found;
} okm_verdict_t;

// Shadow of the keyword search. It tracks the configuration and the search state,
// queues a verdict for every string end and checks result words against them in order.
class okm_scoreboard;
  logic [okm_pkg::KW_W-1:0]    keyword [okm_pkg::KW_REGS];
  logic [okm_pkg::LENS_W-1:0]  lengths;
  logic [okm_pkg::COUNT_W-1:0] count;
  logic [okm_pkg::CH_W-1:0]    window [okm_pkg::MAX_WORD_LEN_DEF];  // newest first, lowered
  int unsigned                 run_len;  // chars since string start or last keyword hit
  int unsigned                 seeking;  // keyword now being searched for
  okm_verdict_t                verdicts [$];
  int unsigned                 mismatches;

  function new();
    foreach (keyword[k]) keyword[k] = '0;
    lengths    = '0;
    count      = '0;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    foreach (window[i]) window[i] = '0;
    run_len = 0;
    seeking = 0;
  endfunction

  function void set_reg(logic [okm_pkg::REG_SEL_W-1:0] idx, logic [okm_pkg::APB_DW-1:0] value);
    case (idx)
      okm_pkg::REG_KW0, okm_pkg::REG_KW1, okm_pkg::REG_KW2, okm_pkg::REG_KW3: begin
        keyword[idx - okm_pkg::REG_KW0] = value[okm_pkg::KW_W-1:0];
      end
      okm_pkg::REG_LENS: begin
        lengths = value[okm_pkg::LENS_W-1:0];
      end
      okm_pkg::REG_COUNT: begin
        count = value[okm_pkg::COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Only A..Z fold; every other byte compares as it is.
  function logic [okm_pkg::CH_W-1:0] lower(logic [okm_pkg::CH_W-1:0] c);
    return (c >= "A" && c <= "Z") ? (c ^ 8'h20) : c;
  endfunction

  function int unsigned in_use();
    int unsigned n;
    n = count;
    if (n > okm_pkg::MAX_WORDS_DEF) n = okm_pkg::MAX_WORDS_DEF;
    if (n > okm_pkg::KW_REGS) n = okm_pkg::KW_REGS;
    return n;
  endfunction

  function int unsigned key_len(int unsigned k);
    int unsigned len;
    len = lengths[k*okm_pkg::LEN_F_W +: okm_pkg::LEN_F_W];
    return (len > okm_pkg::MAX_WORD_LEN_DEF) ? okm_pkg::MAX_WORD_LEN_DEF : len;
  endfunction

  function void pass_empty();
    while (seeking < in_use() && key_len(seeking) == 0) seeking++;
  endfunction

  function bit window_hit(int unsigned k);
    int unsigned len;
    len = key_len(k);
    if (len == 0 || run_len < len) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (window[len-1-i] != lower(keyword[k][i*okm_pkg::CH_W +: okm_pkg::CH_W])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_word(logic [okm_pkg::CH_W-1:0] c, logic has_char, logic last);
    int unsigned  n;
    okm_verdict_t v;
    pass_empty();
    n = in_use();
    if (has_char) begin
      for (int i = okm_pkg::MAX_WORD_LEN_DEF - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = lower(c);
      if (run_len < okm_pkg::MAX_WORD_LEN_DEF) run_len++;
      if (seeking < n && window_hit(seeking)) begin
        seeking++;
        run_len = 0;
        pass_empty();
      end
    end
    if (last) begin
      v.words_found = okm_pkg::WORDS_W'((seeking > n) ? n : seeking);
      v.matched     = (seeking >= n);
      verdicts.push_back(v);
      restart();
    end
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  function void check_verdict(logic matched, logic [okm_pkg::WORDS_W-1:0] words_found);
    okm_verdict_t want;
    if (verdicts.size() == 0) begin
      report($sformatf("unexpected result word: matched %0b words_found %0d",
                       matched, words_found));
      return;
    end
    want = verdicts.pop_front();
    if (want.matched !== matched || want.words_found !== words_found) begin
      report($sformatf("expected matched %0b words_found %0d, got matched %0b words_found %0d",
                       want.matched, want.words_found, matched, words_found));
    end
  endfunction
endclass

module tb_ordered_keyword_matcher;

  // No word accepted on either channel for this many cycles means the block has hung.
  localparam int STALL_LIMIT = 5000;
  // Character words per random phase; nine phases give roughly 900.
  localparam int PHASE_WORDS = 100;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [okm_pkg::APB_AW-1:0]   paddr;
  logic [okm_pkg::APB_DW-1:0]   pwdata;
  logic [okm_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  okm_char_if chars ();
  okm_res_if  result ();

  okm_scoreboard sb = new();

  int          send_gap;     // percent of cycles the character sender idles
  int          recv_gap;     // percent of cycles the result receiver stalls
  int unsigned words_sent;   // character and string-end words, gap words excluded
  int unsigned quiet_cycles;

  ordered_keyword_matcher u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: check each accepted result word, then pick ready for the next cycle.
  // The watchdog lives here too, since this process runs every cycle.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      sb.check_verdict(result.matched, result.words_found);
    end
    result.ready <= ($urandom_range(99) >= recv_gap);
    if (rst || (chars.valid && chars.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_ordered_keyword_matcher failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Flip the case of a letter half of the time; leave other bytes alone.
  function automatic logic [okm_pkg::CH_W-1:0] mixed_case(logic [okm_pkg::CH_W-1:0] c);
    if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  // Filler mostly drawn from the keyword bytes so that near misses are common.
  function automatic logic [okm_pkg::CH_W-1:0] noise_char();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return mixed_case(sb.keyword[$urandom_range(3)][$urandom_range(7)*8 +: 8]);
    if (pick < 9) return mixed_case(8'("a" + $urandom_range(3)));
    return 8'($urandom);
  endfunction

  // Offer one word and hold it until taken. Idle cycles drop valid first.
  task automatic send_word(input logic [okm_pkg::CH_W-1:0] c, input logic has_char,
                           input logic last);
    while ($urandom_range(99) < send_gap) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid    <= 1'b1;
    chars.ch       <= c;
    chars.has_char <= has_char;
    chars.last     <= last;
    do @(posedge clk); while (!chars.ready);
    sb.note_word(c, has_char, last);
    if (has_char || last) words_sent++;
  endtask

  // Send n characters, first in the lowest byte. With empty_tail the string is closed
  // by a word that carries no character.
  task automatic send_packed(input logic [127:0] text, input int n, input bit empty_tail);
    for (int i = 0; i < n; i++) begin
      send_word(text[i*8 +: 8], 1'b1, !empty_tail && i == n - 1);
    end
    if (empty_tail || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // Mostly well-formed strings: the keywords in order with random case and filler
  // between. Some drop or cut short one keyword, a few are filler alone.
  task automatic send_random_string();
    logic [okm_pkg::CH_W-1:0] text [$];
    int unsigned              shape;
    int unsigned              drop;
    int unsigned              keep;
    bit                       tail;
    shape = $urandom_range(9);
    drop  = $urandom_range(okm_pkg::KW_REGS - 1);
    repeat ($urandom_range(3)) text.push_back(noise_char());
    if (shape < 9) begin
      for (int k = 0; k < okm_pkg::KW_REGS; k++) begin
        keep = sb.key_len(k);
        if (k == drop && shape == 7) keep = 0;
        if (k == drop && shape == 8 && keep > 0) keep = keep - 1;
        for (int i = 0; i < keep; i++) text.push_back(mixed_case(sb.keyword[k][i*8 +: 8]));
        repeat ($urandom_range(2)) text.push_back(noise_char());
      end
    end else begin
      repeat ($urandom_range(12)) text.push_back(noise_char());
    end
    tail = (text.size() == 0) || ($urandom_range(5) == 0);
    foreach (text[i]) begin
      if ($urandom_range(11) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(text[i], 1'b1, !tail && i == text.size() - 1);
    end
    if (tail) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // APB write with a setup phase and an access phase; the register takes the value at the access edge.
  // psel stays high so that writes can follow back to back.
  task automatic write_reg(input logic [okm_pkg::REG_SEL_W-1:0] idx,
                           input logic [okm_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {okm_pkg::REG_SEL_LSB{1'b0}}};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
  endtask

  task automatic load_keywords(input logic [63:0] kw0, input logic [63:0] kw1,
                               input logic [63:0] kw2, input logic [63:0] kw3,
                               input logic [15:0] lens, input logic [2:0] cnt);
    write_reg(okm_pkg::REG_KW0, kw0);
    write_reg(okm_pkg::REG_KW1, kw1);
    write_reg(okm_pkg::REG_KW2, kw2);
    write_reg(okm_pkg::REG_KW3, kw3);
    write_reg(okm_pkg::REG_LENS, 64'(lens));
    write_reg(okm_pkg::REG_COUNT, 64'(cnt));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, drain every expected verdict, then let the pipeline go quiet.
  task automatic settle();
    chars.valid <= 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Settings 0..3 are the extremes; the rest are random.
  task automatic configure(input int unsigned setting);
    logic [63:0] kw [okm_pkg::KW_REGS];
    logic [15:0] lens;
    logic [2:0]  cnt;
    bit          letters;
    letters = ($urandom_range(3) != 0);
    foreach (kw[k]) begin
      for (int b = 0; b < 8; b++) begin
        kw[k][b*8 +: 8] = letters ? mixed_case(8'("a" + $urandom_range(3))) : 8'($urandom);
      end
    end
    for (int k = 0; k < okm_pkg::KW_REGS; k++) begin
      lens[k*4 +: 4] = ($urandom_range(7) == 0) ? 4'($urandom_range(8, 15))
                                                : 4'($urandom_range(4));
    end
    cnt = 3'($urandom_range(7));
    case (setting)
      0: begin
        lens = 16'hFFFF;   // every length clamps to eight
        cnt  = 3'd4;
      end
      1: begin
        lens = 16'h1111;
        cnt  = 3'd7;       // too many; acts as four
      end
      2: begin
        lens = 16'h0000;   // all empty: every string finds all four at once
        cnt  = 3'd4;
      end
      3: begin
        cnt = 3'd0;        // nothing in use: every string matches
      end
      default: begin
      end
    endcase
    load_keywords(kw[0], kw[1], kw[2], kw[3], lens, cnt);
  endtask

  initial begin
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    chars.valid    <= 1'b0;
    chars.ch       <= '0;
    chars.has_char <= 1'b0;
    chars.last     <= 1'b0;
    send_gap   = 34;
    recv_gap   = 69;
    words_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: no keyword in use, so an empty string still matches.
    send_packed('0, 0, 1'b1);
    settle();

    // "ab" then "BA": checks case folding, no reuse of the last matched char,
    // a gap word mid-string and a zero byte taken as an ordinary char.
    load_keywords(64'h6261, 64'h4142, '0, '0, 16'h0022, 3'd2);
    send_packed(128'h614261, 3, 1'b0);      // aBa: second keyword would need the shared B
    send_packed(128'h41424241, 4, 1'b0);    // ABBA
    send_word("a", 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word("b", 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word("b", 1'b1, 1'b0);
    send_word("a", 1'b1, 1'b1);
    settle();

    // Count above four, empty keywords at both ends, one single char and one
    // clamped eight-byte keyword holding 0xFF, zero and the bytes either side of A..Z.
    load_keywords('1, 64'h5A, 64'h7B607A41005B40FF, '0, 16'h0F10, 3'd7);
    send_packed(128'h7B605A61005B40FF7A, 9, 1'b1);
    send_packed(128'h60FF5A, 3, 1'b0);      // near miss on the backtick
    settle();

    // Three idling regimes, three settings each.
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_gap = 34;
          recv_gap = 69;
        end
        1: begin
          send_gap = 69;
          recv_gap = 34;
        end
        default: begin
          send_gap = 0;
          recv_gap = 0;
        end
      endcase
      for (int j = 0; j < 3; j++) begin
        configure(regime * 3 + j);
        words_sent = 0;
        while (words_sent < PHASE_WORDS) send_random_string();
        settle();
      end
    end

    if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
      $display("tb_ordered_keyword_matcher passed");
    end else begin
      $display("tb_ordered_keyword_matcher failed");
    end
    $finish;
  end

endmodule
